// File: rtl/lsbr_pkg.sv
// Shared types and constants of the LSB-first bit reader.
`timescale 1ns / 1ps

package lsbr_pkg;

    // Fixed field widths of the request and result channels.
    localparam int CMD_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 5;
    localparam int VALUE_W  = 16;
    localparam int VBITS_W  = 5;
    localparam int STATUS_W = 2;

    // Peek window size and byte geometry.
    localparam int PEEK_BITS = 16;
    localparam int BYTE_BITS = 8;
    localparam int BYTE_MASK = 7;

    // Request commands; the codes above CMD_COPY are ignored.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 3'd0,
        CMD_READ  = 3'd1,
        CMD_PEEK  = 3'd2,
        CMD_ALIGN = 3'd3,
        CMD_COPY  = 3'd4
    } t_cmd;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_FULL      = 2'd2,
        ST_UNALIGNED = 2'd3
    } t_status;

endpackage

// File: rtl/lsb_first_bit_reader_top.sv
// LSB-first bit reader with push, read, peek, align and copy commands.
`timescale 1ns / 1ps
//
// Usage:
//   Requests enter on i_valid / o_ready with i_command, i_byte_in and i_bit_count.
//   Push appends a byte above the held bits, read takes 1 to MAX_READ_BITS bits
//   from the bottom, peek shows the low 16 held bits, align drops the rest of a
//   partly used byte and copy takes one whole byte.
//   Every request gives exactly one result on o_valid / i_ready carrying
//   o_value, o_valid_bits and o_status.
// Timing:
//   The result is registered and appears in the cycle after its request is taken.
//   One request is taken per cycle unless the receiver stalls; the bit buffer and
//   fill count are updated in that same cycle, so the next request sees the new
//   state with no bubble. The limit is the BUFFER_BITS-wide barrel shifts.
// Reset and stall:
//   Reset empties the buffer and drops any pending result. While the receiver
//   stalls, the result is held and o_ready stays low until it is taken.
//
module lsb_first_bit_reader_top
    import lsbr_pkg::*;
#(
    parameter int BUFFER_BITS   = 32,
    parameter int MAX_READ_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [BYTE_W-1:0]   i_byte_in,
    input  logic [COUNT_W-1:0]  i_bit_count,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [VALUE_W-1:0]  o_value,
    output logic [VBITS_W-1:0]  o_valid_bits,
    output logic [STATUS_W-1:0] o_status
);

    localparam int FW = $clog2(BUFFER_BITS + 1);

    logic [BUFFER_BITS-1:0] r_buffer, n_buffer;
    logic [FW-1:0]          r_fill, n_fill;
    logic                   r_out_valid;
    logic [VALUE_W-1:0]     r_value, n_value;
    logic [VBITS_W-1:0]     r_vbits, n_vbits;
    t_status                r_status, n_status;

    logic                   in_acc;
    logic [COUNT_W-1:0]     rd_n;
    logic [FW-1:0]          drop_n;
    logic [FW:0]            push_fill;
    logic [VALUE_W:0]       rd_mask;
    logic [FW-1:0]          odd_bits;

    // A new request is taken whenever the result register is free or draining.
    assign o_ready = !r_out_valid || i_ready;
    assign in_acc  = i_valid && o_ready;

    // Read count saturates at the largest supported field.
    assign rd_n = (i_bit_count > COUNT_W'(MAX_READ_BITS)) ?
                  COUNT_W'(MAX_READ_BITS) : i_bit_count;
    assign rd_mask   = ({{VALUE_W{1'b0}}, 1'b1} << rd_n) - (VALUE_W+1)'(1);
    assign push_fill = {1'b0, r_fill} + (FW+1)'(BYTE_BITS);
    assign odd_bits  = r_fill & FW'(BYTE_MASK);

    // Command decode: result fields and the number of bits consumed.
    always_comb begin
        n_value  = '0;
        n_vbits  = '0;
        n_status = ST_OK;
        drop_n   = '0;
        n_fill   = r_fill;
        n_buffer = r_buffer;
        unique case (t_cmd'(i_command))
            CMD_PUSH: begin
                if (push_fill > (FW+1)'(BUFFER_BITS)) begin
                    n_status = ST_FULL;
                end else begin
                    n_buffer = r_buffer | (BUFFER_BITS'(i_byte_in) << r_fill);
                    n_fill   = push_fill[FW-1:0];
                end
            end
            CMD_READ: begin
                if (rd_n != '0) begin
                    if (r_fill < FW'(rd_n)) begin
                        n_status = ST_SHORT;
                    end else begin
                        n_value = r_buffer[VALUE_W-1:0] & rd_mask[VALUE_W-1:0];
                        n_vbits = VBITS_W'(rd_n);
                        drop_n  = FW'(rd_n);
                    end
                end
            end
            CMD_PEEK: begin
                n_value = r_buffer[VALUE_W-1:0];
                n_vbits = (r_fill > FW'(PEEK_BITS)) ? VBITS_W'(PEEK_BITS)
                                                     : VBITS_W'(r_fill);
            end
            CMD_ALIGN: begin
                drop_n = odd_bits;
            end
            CMD_COPY: begin
                if (odd_bits != '0) begin
                    n_status = ST_UNALIGNED;
                end else if (r_fill < FW'(BYTE_BITS)) begin
                    n_status = ST_SHORT;
                end else begin
                    n_value = VALUE_W'(r_buffer[BYTE_BITS-1:0]);
                    n_vbits = VBITS_W'(BYTE_BITS);
                    drop_n  = FW'(BYTE_BITS);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
        // Consumption shifts the held bits down; push never consumes.
        if (drop_n != '0) begin
            n_buffer = r_buffer >> drop_n;
            n_fill   = r_fill - drop_n;
        end
    end

    // Reader state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_buffer <= n_buffer;
                r_fill   <= n_fill;
            end
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_value  <= n_value;
            r_vbits  <= n_vbits;
            r_status <= n_status;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_value      = r_value;
    assign o_valid_bits = r_vbits;
    assign o_status     = r_status;

    // The fill count never exceeds the buffer size.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(BUFFER_BITS))
        else $error("fill count beyond buffer size");

    // Bits above the fill count are always zero.
    a_clean_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_buffer >> r_fill) == '0)
        else $error("stale bits above fill count");

    // A successful push grows the fill count by one byte.
    a_push_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && t_cmd'(i_command) == CMD_PUSH && n_status == ST_OK)
        |=> (r_fill == $past(r_fill) + FW'(BYTE_BITS)))
        else $error("push did not add a byte");

    // Every taken request yields a pending result in the next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("request without result");

    // A result with no valid bits carries a zero value or an OK status.
    a_value_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_valid_bits == '0) |-> (o_value == '0 || o_status == ST_OK))
        else $error("value bits without a valid count");

endmodule
